FILE: hw/rtl/rvc_pkg.sv
// Shared types, constants and codes of the radial vignetting correction block.
package rvc_pkg;

    localparam int TABLE_DEPTH_DEF    = 4096;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int INDEX_W    = 12;
    localparam int COORD_W    = 13;
    localparam int CENTER_W   = 15;
    localparam int DELTA_W    = 16;
    localparam int MAG_W      = 15;
    localparam int SQUARE_W   = 30;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 16;
    localparam int ROOT_STEPS = 16;
    localparam int DIST_W     = 17;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_NARROW = 16'h00FF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_WIDE   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_WIDE_SAMPLES
    } t_cfg_index;

    typedef struct packed {
        logic                action;
        logic [INDEX_W-1:0]  entry_index;
        logic [GAIN_W-1:0]   entry_gain;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [SAMPLE_W-1:0] in_red;
        logic [SAMPLE_W-1:0] in_green;
        logic [SAMPLE_W-1:0] in_blue;
        logic [SAMPLE_W-1:0] in_alpha;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_red;
        logic [SAMPLE_W-1:0] out_green;
        logic [SAMPLE_W-1:0] out_blue;
        logic [SAMPLE_W-1:0] out_alpha;
    } t_out_item;

    typedef struct packed {
        logic                action;
        logic [INDEX_W-1:0]  entry_index;
        logic [GAIN_W-1:0]   entry_gain;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] alpha;
    } t_side;

    typedef struct packed {
        logic            valid;
        t_side           side;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } t_link;

endpackage

FILE: hw/rtl/rvc_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface rvc_in_if
    import rvc_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rvc_out_if
    import rvc_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rvc_front.sv
// Front stages: offsets from the center, their squares and the squared distance.
module rvc_front
    import rvc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_in_item                   i_item,
    input  logic signed [CENTER_W-1:0] i_center_x,
    input  logic signed [CENTER_W-1:0] i_center_y,
    output t_link                      o_link
);

    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic [MAG_W-1:0]          n_ax;
    logic [MAG_W-1:0]          n_ay;
    t_side                     n_side;

    logic                r_s0_valid;
    t_side               r_s0_side;
    logic [MAG_W-1:0]    r_ax;
    logic [MAG_W-1:0]    r_ay;
    logic                r_s1_valid;
    t_side               r_s1_side;
    logic [SQUARE_W-1:0] r_sqx;
    logic [SQUARE_W-1:0] r_sqy;
    t_link               r_link;
    t_link               n_link;

    always_comb begin
        w_dx = $signed({3'b000, i_item.pixel_x}) - $signed({i_center_x[CENTER_W-1], i_center_x});
        w_dy = $signed({3'b000, i_item.pixel_y}) - $signed({i_center_y[CENTER_W-1], i_center_y});
        n_ax = w_dx[DELTA_W-1] ? MAG_W'(-w_dx) : MAG_W'(w_dx);
        n_ay = w_dy[DELTA_W-1] ? MAG_W'(-w_dy) : MAG_W'(w_dy);
        n_side.action      = i_item.action;
        n_side.entry_index = i_item.entry_index;
        n_side.entry_gain  = i_item.entry_gain;
        n_side.red         = i_item.in_red;
        n_side.green       = i_item.in_green;
        n_side.blue        = i_item.in_blue;
        n_side.alpha       = i_item.in_alpha;
    end

    always_comb begin
        n_link.valid = r_s1_valid;
        n_link.side  = r_s1_side;
        n_link.rem   = SQ_W'(r_sqx) + SQ_W'(r_sqy);
        n_link.root  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_link     <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_side <= n_side;
            r_ax      <= n_ax;
            r_ay      <= n_ay;
            r_s1_side <= r_s0_side;
            r_sqx     <= SQUARE_W'(r_ax) * SQUARE_W'(r_ax);
            r_sqy     <= SQUARE_W'(r_ay) * SQUARE_W'(r_ay);
        end
    end

    assign o_link = r_link;

endmodule

FILE: hw/rtl/rvc_sqrt_cell.sv
// One cell of the square root chain: decides one root bit and passes the item on.
module rvc_sqrt_cell
    import rvc_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_link i_link,
    output t_link o_link
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * STEP);

    logic [SQ_W-1:0] w_trial;
    t_link           n_link;
    t_link           r_link;

    always_comb begin
        w_trial = i_link.root + BIT;
        n_link  = i_link;
        if (i_link.rem >= w_trial) begin
            n_link.rem  = i_link.rem - w_trial;
            n_link.root = (i_link.root >> 1) + BIT;
        end else begin
            n_link.root = i_link.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

FILE: hw/rtl/rvc_back.sv
// Back stages: rounding and clamp, gain table, channel multiply, saturation and output register.
module rvc_back
    import rvc_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_link     i_link,
    input  logic      i_wide,
    input  logic      i_ready,
    output logic      o_en,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int                AW        = $clog2(TABLE_DEPTH);
    localparam logic [DIST_W-1:0] LAST      = DIST_W'(TABLE_DEPTH - 1);
    localparam logic [DIST_W-1:0] DEPTH_EXT = DIST_W'(TABLE_DEPTH);

    logic [DIST_W-1:0] w_dist;
    logic [DIST_W-1:0] w_idx;
    logic [AW-1:0]     n_addr;
    logic              n_we;

    logic                r_a_valid;
    logic                r_a_we;
    logic [AW-1:0]       r_a_addr;
    t_side               r_a_side;
    logic [GAIN_W-1:0]   r_mem [TABLE_DEPTH];
    logic                r_b_valid;
    t_side               r_b_side;
    logic [GAIN_W-1:0]   r_b_gain;
    logic                r_c_valid;
    logic [PROD_W-1:0]   r_c_red;
    logic [PROD_W-1:0]   r_c_green;
    logic [PROD_W-1:0]   r_c_blue;
    logic [SAMPLE_W-1:0] r_c_alpha;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;
    logic [SAMPLE_W-1:0] w_max;
    logic [SAMPLE_W-1:0] w_r;
    logic [SAMPLE_W-1:0] w_g;
    logic [SAMPLE_W-1:0] w_b;
    logic                w_en;

    function automatic logic [SAMPLE_W-1:0] saturate(
        input logic [PROD_W-1:0]   prod,
        input logic [SAMPLE_W-1:0] maxv
    );
        logic [PROD_W-1:0] v;
        v = prod >> GAIN_FRAC_BITS;
        if (v > PROD_W'(maxv)) begin
            return maxv;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    assign w_en = !r_out_valid || i_ready;

    always_comb begin
        w_dist = {1'b0, i_link.root[ROOT_W-1:0]} + DIST_W'(i_link.rem > i_link.root);
        if (w_dist > LAST) begin
            w_dist = LAST;
        end
        w_idx  = DIST_W'(i_link.side.entry_index);
        n_addr = (i_link.side.action == ACT_PIXEL) ? w_dist[AW-1:0] : w_idx[AW-1:0];
        n_we   = i_link.valid && (i_link.side.action == ACT_LOAD) && (w_idx < DEPTH_EXT);
    end

    always_comb begin
        w_max = i_wide ? SAMPLE_MAX_WIDE : SAMPLE_MAX_NARROW;
        w_r   = i_wide ? r_b_side.red   : {8'h00, r_b_side.red[7:0]};
        w_g   = i_wide ? r_b_side.green : {8'h00, r_b_side.green[7:0]};
        w_b   = i_wide ? r_b_side.blue  : {8'h00, r_b_side.blue[7:0]};
        n_out.out_red   = saturate(r_c_red, w_max);
        n_out.out_green = saturate(r_c_green, w_max);
        n_out.out_blue  = saturate(r_c_blue, w_max);
        n_out.out_alpha = r_c_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_a_we      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= i_link.valid;
            r_a_we      <= n_we;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid && (r_b_side.action == ACT_PIXEL);
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_a_we) begin
                r_mem[r_a_addr] <= r_a_side.entry_gain;
            end
            r_b_gain <= r_mem[r_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_addr  <= n_addr;
            r_a_side  <= i_link.side;
            r_b_side  <= r_a_side;
            r_c_red   <= PROD_W'(w_r) * PROD_W'(r_b_gain);
            r_c_green <= PROD_W'(w_g) * PROD_W'(r_b_gain);
            r_c_blue  <= PROD_W'(w_b) * PROD_W'(r_b_gain);
            r_c_alpha <= r_b_side.alpha;
            r_out     <= n_out;
        end
    end

    assign o_en    = w_en;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

FILE: hw/rtl/radial_vignetting_correction.sv
// Top level of the radial vignetting correction block.
// The block takes one transaction per clock while the output is not held, a pixel or a gain
// table load, and corrects each pixel: offset, square and sum registers form the squared
// distance, a chain of sixteen square root cells settles one root bit each, and the back
// stages round and clamp it, read the gain table, multiply the channels and saturate them.
// Loads travel down the same pipeline and write the table in order with the pixel reads, so
// a pixel sees every load taken before it. The table is one memory with a single write and a
// single registered read port; it needs no clearing after reset. When a finished result is
// not taken, the whole pipeline holds and input ready drops until the output moves.
module radial_vignetting_correction
    import rvc_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rvc_in_if.sink                i_pix,
    rvc_out_if.source             o_pix
);

    logic signed [CENTER_W-1:0] r_center_x;
    logic signed [CENTER_W-1:0] r_center_y;
    logic                       r_wide;
    logic                       w_en;
    t_link                      w_chain [ROOT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_wide     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X:     r_center_x <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_CENTER_Y:     r_center_y <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_WIDE_SAMPLES: r_wide     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_pix.ready = w_en;

    rvc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_pix.valid),
        .i_item     (i_pix.data),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_link     (w_chain[0])
    );

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
        rvc_sqrt_cell #(
            .STEP (ROOT_STEPS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_link  (w_chain[k]),
            .o_link  (w_chain[k+1])
        );
    end

    rvc_back #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_chain[ROOT_STEPS]),
        .i_wide  (r_wide),
        .i_ready (o_pix.ready),
        .o_en    (w_en),
        .o_valid (o_pix.valid),
        .o_item  (o_pix.data)
    );

endmodule

FILE: hw/rtl/rvc_checker.sv
// Port level checks of the radial vignetting correction block and their binding.
module rvc_checker
    import rvc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("Input not ready although the output can move.");

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("Input stalled without a blocked output.");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid right after reset.");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("Stalled output transaction changed.");

endmodule

bind radial_vignetting_correction rvc_checker u_rvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);
